// ----- design/ro_pkg.sv -----
// Shared types, constants and helper functions of the ridge orientation estimator.
// No dependencies; ro_ctrl, ro_dp and the top level import this package.
package ro_pkg;

    localparam int CORDIC_STEPS = 18;
    localparam int CW           = 60;   // CORDIC x/y width
    localparam int ZW           = 24;   // angle accumulator width
    localparam int SW           = 32;   // gradient sum width

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_READ,
        S_WAIT,
        S_GRAD,
        S_MUL,
        S_ACC,
        S_CINIT,
        S_CORD,
        S_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       wr;
        logic       load;
        logic       rd;
        logic [2:0] k;
        logic [4:0] ii;
        logic [4:0] jj;
        logic       grad;
        logic       mul;
        logic       acc;
        logic       cinit;
        logic       cstep;
        logic [4:0] ci;
        logic       fin;
    } cmd_t;

    typedef struct packed {
        logic border;
    } sts_t;

    // Column offset of the k-th pixel read of one window step
    function automatic logic [1:0] off_dx(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // Row offset of the k-th pixel read of one window step
    function automatic logic [1:0] off_dy(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0, 3'd3, 3'd5: r = 2'd0;
            3'd1, 3'd6:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // atan(2^-i) in units of pi/2^20
    function automatic logic [ZW-1:0] atan_a(input logic [4:0] i);
        logic [ZW-1:0] r;
        case (i)
            5'd0:    r = 24'd262144;
            5'd1:    r = 24'd154753;
            5'd2:    r = 24'd81767;
            5'd3:    r = 24'd41506;
            5'd4:    r = 24'd20834;
            5'd5:    r = 24'd10427;
            5'd6:    r = 24'd5215;
            5'd7:    r = 24'd2608;
            5'd8:    r = 24'd1304;
            5'd9:    r = 24'd652;
            5'd10:   r = 24'd326;
            5'd11:   r = 24'd163;
            5'd12:   r = 24'd81;
            5'd13:   r = 24'd41;
            5'd14:   r = 24'd20;
            5'd15:   r = 24'd10;
            5'd16:   r = 24'd5;
            5'd17:   r = 24'd3;
            default: r = 24'd0;
        endcase
        return r;
    endfunction

    // Right shift that truncates toward zero
    function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                       input logic [4:0] s);
        logic signed [CW-1:0] bias;
        bias = v[CW-1] ? ((CW'(1) <<< s) - CW'(1)) : '0;
        return (v + bias) >>> s;
    endfunction

endpackage

// ----- design/ro_ctrl.sv -----
// Sequencer of the ridge orientation estimator: state machine and loop counters.
// Depends on ro_pkg; drives the command struct of ro_dp.
module ro_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic           action,
    input  logic [3:0]     w,
    input  ro_pkg::sts_t   sts,
    output ro_pkg::cmd_t   cmd,
    output logic           busy,
    output logic           done
);
    import ro_pkg::*;

    state_t     state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [4:0] ii_reg, ii_next;
    logic [4:0] jj_reg, jj_next;
    logic [4:0] ci_reg, ci_next;
    logic [4:0] last;
    logic       accept;

    assign last   = {w, 1'b0} - 5'd2;
    assign accept = start && (state_reg == S_IDLE);

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            ii_reg    <= '0;
            jj_reg    <= '0;
            ci_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            ii_reg    <= ii_next;
            jj_reg    <= jj_next;
            ci_reg    <= ci_next;
        end
    end

    // Next state and counter advance
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        ii_next    = ii_reg;
        jj_next    = jj_reg;
        ci_next    = ci_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && action)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                k_next  = '0;
                ii_next = '0;
                jj_next = '0;
                if (sts.border)
                    state_next = S_FIN;
                else if (w == 4'd0)
                    state_next = S_CINIT;
                else
                    state_next = S_READ;
            end
            S_READ:
            begin
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                    state_next = S_WAIT;
            end
            S_WAIT:  state_next = S_GRAD;
            S_GRAD:  state_next = S_MUL;
            S_MUL:   state_next = S_ACC;
            S_ACC:
            begin
                if (jj_reg == last)
                begin
                    jj_next = '0;
                    if (ii_reg == last)
                        state_next = S_CINIT;
                    else
                    begin
                        ii_next    = ii_reg + 5'd1;
                        state_next = S_READ;
                    end
                end
                else
                begin
                    jj_next    = jj_reg + 5'd1;
                    state_next = S_READ;
                end
            end
            S_CINIT:
            begin
                ci_next    = '0;
                state_next = S_CORD;
            end
            S_CORD:
            begin
                ci_next = ci_reg + 5'd1;
                if (ci_reg == 5'(CORDIC_STEPS - 1))
                    state_next = S_FIN;
            end
            S_FIN:   state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd       = '0;
        cmd.k     = k_reg;
        cmd.ii    = ii_reg;
        cmd.jj    = jj_reg;
        cmd.ci    = ci_reg;
        cmd.wr    = accept && !action;
        cmd.load  = accept && action;
        cmd.rd    = (state_reg == S_READ);
        cmd.grad  = (state_reg == S_GRAD);
        cmd.mul   = (state_reg == S_MUL);
        cmd.acc   = (state_reg == S_ACC);
        cmd.cinit = (state_reg == S_CINIT);
        cmd.cstep = (state_reg == S_CORD);
        cmd.fin   = (state_reg == S_FIN);
        busy      = (state_reg != S_IDLE);
        done      = (state_reg == S_DONE);
    end

endmodule

// ----- design/ro_dp.sv -----
// Datapath of the ridge orientation estimator: pixel store, gradient sums, CORDIC.
// Depends on ro_pkg; steered by the command struct from ro_ctrl.
module ro_dp #(
    parameter int IMG_COLS = 256,
    parameter int IMG_ROWS = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    input  ro_pkg::cmd_t   cmd,
    input  logic [7:0]     col,
    input  logic [7:0]     row,
    input  logic [7:0]     pixel,
    input  logic [3:0]     w,
    output ro_pkg::sts_t   sts,
    output logic [15:0]    angle,
    output logic           in_interior
);
    import ro_pkg::*;

    localparam int DEPTH  = IMG_COLS * IMG_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [11:0] COLS_L = 12'(IMG_COLS);
    localparam logic [11:0] ROWS_L = 12'(IMG_ROWS);

    logic [7:0]             mem [DEPTH];
    logic [7:0]             mem_q_reg;
    logic                   rd_v_reg;
    logic [2:0]             rd_k_reg;
    logic [7:0]             p_reg [8];
    logic [7:0]             cx_reg, cy_reg;
    logic                   border_reg;
    logic signed [11:0]     bx_reg, by_reg;
    logic signed [23:0]     pxx_reg, pyy_reg, pxy_reg;
    logic signed [SW-1:0]   sxx_reg, syy_reg, sxy_reg;
    logic signed [CW-1:0]   x_reg, y_reg;
    logic signed [ZW-1:0]   z_reg;
    logic                   zero_reg;
    logic [15:0]            angle_reg;
    logic                   int_reg;

    logic [10:0]            xs, ys;
    logic [ADDR_W-1:0]      rd_addr, wr_addr;
    logic                   wr_ok;
    logic                   border_in;
    logic signed [SW-1:0]   gx, gy;
    logic signed [CW-1:0]   x0, y0, shx, shy;
    logic signed [ZW-1:0]   tz;

    // Window pixel address
    assign xs = {3'b0, cx_reg} + {6'b0, cmd.ii} + {9'b0, off_dx(cmd.k)} - {7'b0, w};
    assign ys = {3'b0, cy_reg} + {6'b0, cmd.jj} + {9'b0, off_dy(cmd.k)} - {7'b0, w};
    assign rd_addr = ADDR_W'(32'(ys) * 32'(IMG_COLS) + 32'(xs));
    assign wr_addr = ADDR_W'(32'(row) * 32'(IMG_COLS) + 32'(col));
    assign wr_ok   = (12'(col) < COLS_L) && (12'(row) < ROWS_L);

    // Border test of the queried position
    assign border_in = (12'(col) < 12'(w) + 12'd1) || (12'(col) + 12'(w) + 12'd1 >= COLS_L)
                    || (12'(row) < 12'(w) + 12'd1) || (12'(row) + 12'(w) + 12'd1 >= ROWS_L);
    assign sts.border = border_reg;

    // Pixel store: one write or one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.wr && wr_ok)
            mem[wr_addr] <= pixel;
        if (cmd.rd)
            mem_q_reg <= mem[rd_addr];
    end

    // Track which pixel the read data belongs to
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            rd_k_reg   <= '0;
            border_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= cmd.rd;
            rd_k_reg <= cmd.k;
            if (cmd.load)
                border_reg <= border_in;
        end
    end

    // Angle setup: fold the left half plane
    assign gx = sxx_reg - syy_reg;
    assign gy = sxy_reg <<< 1;
    assign x0 = CW'(gx) <<< 24;
    assign y0 = CW'(gy) <<< 24;
    assign shx = shr_trunc(x_reg, cmd.ci);
    assign shy = shr_trunc(y_reg, cmd.ci);
    assign tz  = (z_reg + ZW'(16)) >>> 5;

    // Gradients, products, sums and CORDIC iterations
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
            p_reg[rd_k_reg] <= mem_q_reg;
        if (cmd.load)
        begin
            cx_reg  <= col;
            cy_reg  <= row;
            sxx_reg <= '0;
            syy_reg <= '0;
            sxy_reg <= '0;
        end
        if (cmd.grad)
        begin
            bx_reg <= 12'(p_reg[5]) + (12'(p_reg[6]) <<< 1) + 12'(p_reg[7])
                    - 12'(p_reg[0]) - (12'(p_reg[1]) <<< 1) - 12'(p_reg[2]);
            by_reg <= 12'(p_reg[2]) + (12'(p_reg[4]) <<< 1) + 12'(p_reg[7])
                    - 12'(p_reg[0]) - (12'(p_reg[3]) <<< 1) - 12'(p_reg[5]);
        end
        if (cmd.mul)
        begin
            pxx_reg <= bx_reg * bx_reg;
            pyy_reg <= by_reg * by_reg;
            pxy_reg <= bx_reg * by_reg;
        end
        if (cmd.acc)
        begin
            sxx_reg <= sxx_reg + SW'(pxx_reg);
            syy_reg <= syy_reg + SW'(pyy_reg);
            sxy_reg <= sxy_reg + SW'(pxy_reg);
        end
        if (cmd.cinit)
        begin
            zero_reg <= (gx == '0) && (gy == '0);
            if (gx < 0)
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= (gy >= 0) ? ZW'(1 << 20) : -ZW'(1 << 20);
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        if (cmd.cstep)
        begin
            if (!y_reg[CW-1])
            begin
                x_reg <= x_reg + shy;
                y_reg <= y_reg - shx;
                z_reg <= z_reg + atan_a(cmd.ci);
            end
            else
            begin
                x_reg <= x_reg - shy;
                y_reg <= y_reg + shx;
                z_reg <= z_reg - atan_a(cmd.ci);
            end
        end
        if (cmd.fin)
        begin
            if (border_reg)
            begin
                angle_reg <= '0;
                int_reg   <= 1'b0;
            end
            else
            begin
                angle_reg <= zero_reg ? 16'h8000 : (16'h8000 - tz[15:0]);
                int_reg   <= 1'b1;
            end
        end
    end

    assign angle       = angle_reg;
    assign in_interior = int_reg;

endmodule

// ----- design/ridge_orientation_estimator.sv -----
// Top level of the ridge orientation estimator: APB register, sequencer, datapath.
// Depends on ro_pkg, ro_ctrl and ro_dp.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------
//  input    | start, busy            | action, col, row, pixel
//  result   | done (one-cycle beat)  | angle, in_interior
//  config   | psel, penable, pready  | paddr, pwrite, pwdata, prdata
//
// A pixel write leaves busy low. A border query passes through check, finish and done.
// An interior query walks (2w-1)^2 window steps for w >= 1 and none at w = 0:
// each window step issues eight reads on the single store port, then
// gradient, multiply, sum; 18 CORDIC iterations follow. Reset clears control only;
// the store is undefined until written. Results are shown on done for one cycle;
// angle and in_interior keep their values until the next query updates them.
module ridge_orientation_estimator #(
    parameter int IMG_COLS = 256,
    parameter int IMG_ROWS = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [7:0]  pixel,
    output logic        done,
    output logic [15:0] angle,
    output logic        in_interior,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ro_pkg::*;

    localparam logic ADDR_WINDOW_HALF = 1'b0;

    logic [3:0] window_half_reg;
    cmd_t       cmd;
    sts_t       sts;

    // Register file: window half width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_half_reg <= 4'd4;
        else if (psel && penable && pwrite && paddr[2] == ADDR_WINDOW_HALF)
            window_half_reg <= pwdata[3:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_WINDOW_HALF) ? {28'b0, window_half_reg} : '0;

    ro_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .w      (window_half_reg),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    ro_dp #(
        .IMG_COLS (IMG_COLS),
        .IMG_ROWS (IMG_ROWS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .col         (col),
        .row         (row),
        .pixel       (pixel),
        .w           (window_half_reg),
        .sts         (sts),
        .angle       (angle),
        .in_interior (in_interior)
    );

endmodule

// ----- design/ro_checker.sv -----
// Port-level checks of the ridge orientation estimator, bound to the top level.
// Depends only on the top level's ports.
module ro_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        action,
    input logic        done,
    input logic [15:0] angle,
    input logic        in_interior
);

    // A result beat lasts one cycle
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result beat longer than one cycle");

    // Results appear only while a query is in progress
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result beat outside a query");

    // Border results carry a zero angle
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_interior) |-> (angle == 16'd0)) else $error("border angle not zero");

    // A pixel write leaves the block free
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !action) |=> !busy) else $error("write made block busy");

    // A query occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action) |=> (busy && !done)) else $error("query not taken");

endmodule

bind ridge_orientation_estimator ro_port_checks u_ro_port_checks (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .done        (done),
    .angle       (angle),
    .in_interior (in_interior)
);

// ----- tb/ro_checker.sv -----
// Orientation checker: watches the command, result and register channels of the
// ridge orientation estimator, predicts each query result and compares it.
// Stands alone; needs no package of the design.
module ro_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        action,
    input  logic [7:0]  col,
    input  logic [7:0]  row,
    input  logic [7:0]  pixel,
    input  logic        done,
    input  logic [15:0] angle,
    input  logic        in_interior,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    localparam int          COLS       = 256;
    localparam int          ROWS       = 256;
    localparam logic        ACT_WRITE  = 1'b0;
    localparam logic        ACT_QUERY  = 1'b1;
    localparam logic [2:0]  ADDR_WHALF = 3'd0;

    typedef struct packed {
        logic        interior;
        logic [15:0] angle;
    } orient_t;

    logic [7:0]  frame [COLS*ROWS];
    logic [3:0]  whalf;
    orient_t     orient_q [$];
    longint      arctan_tab [18] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215,
                                     2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3};

    function automatic longint px(int x, int y);
        return longint'(frame[y*COLS + x]);
    endfunction

    function automatic longint trunc_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v) >>> s);
    endfunction

    // Least-squares gradient orientation at (cx, cy) with the present window
    function automatic orient_t ridge_orientation(int cx, int cy);
        orient_t r;
        int      w;
        longint  sxx, syy, sxy, bx, by, gx, gy, x, y, z, nx, ny, t;
        w   = int'(whalf);
        sxx = 0;
        syy = 0;
        sxy = 0;
        r   = '0;
        if (cx < w+1 || cx >= COLS-w-1 || cy < w+1 || cy >= ROWS-w-1)
            return r;
        for (int i = cx-w; i < cx+w-1; i++)
        begin
            for (int j = cy-w; j < cy+w-1; j++)
            begin
                bx = px(i+2, j) + 2*px(i+2, j+1) + px(i+2, j+2)
                   - px(i, j) - 2*px(i, j+1) - px(i, j+2);
                by = px(i, j+2) + 2*px(i+1, j+2) + px(i+2, j+2)
                   - px(i, j) - 2*px(i+1, j) - px(i+2, j);
                sxx += bx*bx;
                syy += by*by;
                sxy += bx*by;
            end
        end
        r.interior = 1'b1;
        gx = sxx - syy;
        gy = 2*sxy;
        if (gx == 0 && gy == 0)
        begin
            r.angle = 16'd32768;
            return r;
        end
        x = gx <<< 24;
        y = gy <<< 24;
        z = 0;
        // fold the left half plane onto the right one
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd1048576 : -64'sd1048576;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 18; i++)
        begin
            if (y >= 0)
            begin
                nx = x + trunc_shift(y, i);
                ny = y - trunc_shift(x, i);
                z += arctan_tab[i];
            end
            else
            begin
                nx = x - trunc_shift(y, i);
                ny = y + trunc_shift(x, i);
                z -= arctan_tab[i];
            end
            x = nx;
            y = ny;
        end
        t = ((z + 16 + (64'sd1 <<< 21)) >>> 5) - 65536;
        r.angle = 16'(32768 - t);
        return r;
    endfunction

    // Compare results first, then take in the beat accepted at this edge
    always @(posedge clk or negedge rst_n)
    begin
        orient_t expd;
        if (!rst_n)
        begin
            whalf      <= 4'd4;
            fail_count <= 0;
            pending    <= 0;
            orient_q.delete();
        end
        else
        begin
            if (done)
            begin
                if (orient_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result angle=%0d interior=%0b",
                                 angle, in_interior);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    expd = orient_q.pop_front();
                    if (expd.angle !== angle || expd.interior !== in_interior)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected angle=%0d interior=%0b, got %0d %0b",
                                     expd.angle, expd.interior, angle, in_interior);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy)
            begin
                if (action == ACT_WRITE)
                    frame[int'(row)*COLS + int'(col)] = pixel;
                else if (action == ACT_QUERY)
                    orient_q = {orient_q, ridge_orientation(int'(col), int'(row))};
            end
            if (psel && penable && pwrite && pready && paddr == ADDR_WHALF)
                whalf <= pwdata[3:0];
            pending <= orient_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the ridge orientation estimator testbench: clock, reset, patch load,
// directed and random queries across window settings. Depends on ro_checker and the top level.
module tb_top;

    localparam logic       ACT_WRITE  = 1'b0;
    localparam logic       ACT_QUERY  = 1'b1;
    localparam logic [2:0] ADDR_WHALF = 3'd0;
    localparam int         REG_LO     = 100;   // loaded patch, first column and row
    localparam int         REG_HI     = 117;   // loaded patch, last column and row

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = 1'b0;
    logic [7:0]  col = '0;
    logic [7:0]  row = '0;
    logic [7:0]  pixel = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        busy, done, in_interior, pready;
    logic [15:0] angle;
    logic [31:0] prdata;
    int          fail_count, pending;
    int          n_queries, n_writes;
    bit          allow_idle;

    ridge_orientation_estimator DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .col(col), .row(row), .pixel(pixel), .done(done), .angle(angle),
        .in_interior(in_interior), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    ro_checker u_checker (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .col(col), .row(row), .pixel(pixel), .done(done), .angle(angle),
        .in_interior(in_interior), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Present one beat and hold it until accepted; maybe idle afterwards
    task automatic send(logic act, logic [7:0] c, logic [7:0] r, logic [7:0] p);
        start  <= 1'b1;
        action <= act;
        col    <= c;
        row    <= r;
        pixel  <= p;
        do
            @(posedge clk);
        while (busy);
        if (act == ACT_QUERY)
            n_queries++;
        else
            n_writes++;
        if (allow_idle && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge clk);
        end
    endtask

    // Drain outstanding results, then write the window half width
    task automatic set_window(logic [3:0] w);
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WHALF;
        pwdata  <= {8'($urandom_range(255)), 20'h0, w};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Choose a query position whose window reads only loaded pixels
    task automatic pick_position(input logic [3:0] w, output logic [7:0] c,
                                 output logic [7:0] r);
        int wi;
        int a;
        int b;
        wi = int'(w);
        if (wi == 0)
        begin
            c = 8'($urandom_range(255));
            r = 8'($urandom_range(255));
        end
        else if (wi <= 8 && $urandom_range(1) == 0)
        begin
            c = 8'(REG_LO + wi + int'($urandom_range(REG_HI - REG_LO - 2*wi)));
            r = 8'(REG_LO + wi + int'($urandom_range(REG_HI - REG_LO - 2*wi)));
        end
        else
        begin
            // border band: one coordinate within w of an edge
            a = int'($urandom_range(255));
            b = int'($urandom_range(wi));
            if ($urandom_range(1) == 0)
                b = 255 - b;
            if ($urandom_range(1) == 0)
            begin
                c = 8'(a);
                r = 8'(b);
            end
            else
            begin
                c = 8'(b);
                r = 8'(a);
            end
        end
    endtask

    task automatic random_phase(logic [3:0] w, int n);
        logic [7:0] c;
        logic [7:0] r;
        set_window(w);
        for (int k = 0; k < n; k++)
        begin
            if ($urandom_range(9) < 5)
            begin
                pick_position(w, c, r);
                send(ACT_QUERY, c, r, 8'($urandom_range(255)));
            end
            else
                send(ACT_WRITE, 8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("ridge_orientation_estimator test failed");
        $finish;
    end

    initial
    begin
        logic [3:0] wlist [7];
        int         nlist [7];
        logic [7:0] p;
        wlist      = '{4'd8, 4'd0, 4'd2, 4'd15, 4'd3, 4'd6, 4'd5};
        nlist      = '{8, 8, 8, 6, 8, 8, 8};
        n_queries  = 0;
        n_writes   = 0;
        allow_idle = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the query patch: flat corner, ramp corner, noise elsewhere
        for (int y = REG_LO; y <= REG_HI; y++)
        begin
            for (int x = REG_LO; x <= REG_HI; x++)
            begin
                if (x <= 105 && y <= 105)
                    p = 8'd77;
                else if (x >= 110 && y >= 110)
                    p = 8'((x-110)*9 + (y-110)*4);
                else
                    p = 8'($urandom_range(255));
                send(ACT_WRITE, 8'(x), 8'(y), p);
            end
        end

        // Load two 3x3 tiles near opposite corners for the half width 1 window
        for (int y = 1; y <= 3; y++)
        begin
            for (int x = 1; x <= 3; x++)
            begin
                send(ACT_WRITE, 8'(x), 8'(y), 8'($urandom_range(255)));
                send(ACT_WRITE, 8'(x + 251), 8'(y + 251), 8'($urandom_range(255)));
            end
        end

        // Directed queries at the reset window: borders and patch interior
        allow_idle = 1'b1;
        send(ACT_QUERY, 8'd0, 8'd0, 8'd0);
        send(ACT_QUERY, 8'd255, 8'd255, 8'd255);
        send(ACT_QUERY, 8'd4, 8'd110, 8'd0);
        send(ACT_QUERY, 8'd110, 8'd4, 8'd0);
        send(ACT_QUERY, 8'd251, 8'd110, 8'd0);
        send(ACT_QUERY, 8'd110, 8'd251, 8'd0);
        send(ACT_QUERY, 8'd104, 8'd104, 8'd0);
        send(ACT_QUERY, 8'd108, 8'd108, 8'd0);
        send(ACT_QUERY, 8'd113, 8'd113, 8'd0);

        // Half width 1: first and last interior positions at both corners, and border neighbours
        set_window(4'd1);
        send(ACT_QUERY, 8'd2, 8'd2, 8'd0);
        send(ACT_QUERY, 8'd1, 8'd2, 8'd0);
        send(ACT_QUERY, 8'd2, 8'd1, 8'd0);
        send(ACT_QUERY, 8'd253, 8'd253, 8'd0);
        send(ACT_QUERY, 8'd254, 8'd253, 8'd0);
        send(ACT_QUERY, 8'd253, 8'd254, 8'd0);

        // Random mixes of rewrites and queries over several window widths
        for (int k = 0; k < 7; k++)
        begin
            if (k == 6)
                allow_idle = 1'b0;
            random_phase(wlist[k], nlist[k]);
        end

        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d pixel writes and %0d orientation queries", n_writes, n_queries);
        $display("window half widths 4, 1, 8, 0, 2, 15, 3, 6 and 5: border bands, "
                 , "corner tiles and a loaded patch, with and without gaps");
        if (fail_count == 0)
            $display("ridge_orientation_estimator test passed");
        else
            $display("ridge_orientation_estimator test failed");
        $finish;
    end

endmodule

// ----- ridge_orientation_estimator.f -----
design/ro_pkg.sv
design/ro_ctrl.sv
design/ro_dp.sv
design/ridge_orientation_estimator.sv
design/ro_checker.sv
tb/ro_checker.sv
tb/tb_top.sv
